@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int SCROLL_END  = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  BLANK_ATTR   = 8'h0F;
  localparam logic [15:0] BLANK_CELL   = {BLANK_ATTR, CH_SPACE};

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        char_code;
    logic              idx_ok;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

  typedef struct packed {
    logic        done;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] pos;
    logic [15:0] cell_val;
    logic        scrolled;
  } res_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row * COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the front classifier and the back engine.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcw_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output tcw_pkg::cmd_t  head,
  output tcw_pkg::q_stat_t stat
);
  import tcw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = entry[rd_ptr];
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Accepts commands and classifies them into queue entries.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                 start,
  input  logic [1:0]           func,
  input  logic [7:0]           char_code,
  input  logic [10:0]          cell_index,
  input  tcw_pkg::q_stat_t     q_stat,
  input  tcw_pkg::back_stat_t  back_stat,
  output logic                 busy,
  output logic                 push,
  output tcw_pkg::cmd_t        push_cmd
);
  import tcw_pkg::*;

  assign busy = q_stat.full || back_stat.init_busy;
  assign push = start && !busy;

  always_comb begin
    push_cmd.char_code = char_code;
    push_cmd.idx_ok    = (32'(cell_index) < 32'(CELLS));
    push_cmd.addr      = ADDR_W'(cell_index);
    unique case (func)
      FUNC_PUT: begin
        if (char_code == CH_NEWLINE) begin
          push_cmd.op = OP_NEWLINE;
        end else if (char_code == CH_BACKSPACE) begin
          push_cmd.op = OP_BACKSPACE;
        end else begin
          push_cmd.op = OP_PUT;
        end
      end
      FUNC_READ:  push_cmd.op = OP_READ;
      FUNC_CLEAR: push_cmd.op = OP_CLEAR;
      default:    push_cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ rtl/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued commands on the cell store: put, read, clear and scroll.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  tcw_pkg::q_stat_t    q_stat,
  input  tcw_pkg::cmd_t       head,
  output tcw_pkg::back_stat_t stat,
  output tcw_pkg::res_t       res
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_CLEAR,
    S_SCROLL,
    S_BLANK
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_ADDR = ADDR_W'(SCROLL_END);

  state_t            state;
  cmd_t              cmd;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic              scroll_req;
  logic [ADDR_W-1:0] sc;
  logic [ADDR_W-1:0] wr_q;
  logic              rd_vld;
  logic [7:0]        attr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.pop       = (state == S_IDLE) && !q_stat.empty;
  assign stat.init_busy = (state == S_INIT);

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = sc;
    ram_wdata  = BLANK_CELL;
    ram_raddr  = cmd.addr;
    col_next   = col;
    row_next   = row;
    scroll_req = 1'b0;
    unique case (state)
      S_INIT, S_CLEAR, S_BLANK: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        unique case (cmd.op)
          OP_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(row, col);
            ram_wdata = {attr, cmd.char_code};
            if (col == COL_W'(COLUMNS - 1)) begin
              col_next = '0;
              if (row == ROW_W'(ROWS - 1)) begin
                scroll_req = 1'b1;
              end else begin
                row_next = row + 1'b1;
              end
            end else begin
              col_next = col + 1'b1;
            end
          end
          OP_NEWLINE: begin
            col_next = '0;
            if (row == ROW_W'(ROWS - 1)) begin
              scroll_req = 1'b1;
            end else begin
              row_next = row + 1'b1;
            end
          end
          OP_BACKSPACE: begin
            if (col != '0) begin
              col_next  = col - 1'b1;
              ram_we    = 1'b1;
              ram_waddr = cell_addr(row, col - 1'b1);
            end
          end
          OP_CLEAR: begin
            col_next = '0;
            row_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_SCROLL: begin
        ram_we    = rd_vld;
        ram_waddr = wr_q;
        ram_wdata = ram_rdata;
        ram_raddr = sc + ADDR_W'(COLUMNS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sc       <= '0;
      col      <= '0;
      row      <= '0;
      rd_vld   <= 1'b0;
      attr     <= BLANK_ATTR;
      res.done <= 1'b0;
    end else begin
      res.done     <= 1'b0;
      res.col      <= 7'(col_next);
      res.row      <= 5'(row_next);
      res.pos      <= 11'(cell_addr(row_next, col_next));
      res.cell_val <= '0;
      res.scrolled <= 1'b0;
      col          <= col_next;
      row          <= row_next;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      unique case (state)
        S_INIT: begin
          sc <= sc + 1'b1;
          if (sc == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_stat.empty) begin
            cmd   <= head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd.op)
            OP_READ: begin
              if (cmd.idx_ok) begin
                state <= S_RDWAIT;
              end else begin
                res.done <= 1'b1;
                state    <= S_IDLE;
              end
            end
            OP_CLEAR: begin
              sc    <= '0;
              state <= S_CLEAR;
            end
            default: begin
              if (scroll_req) begin
                sc     <= '0;
                rd_vld <= 1'b0;
                state  <= S_SCROLL;
              end else begin
                res.done <= 1'b1;
                state    <= S_IDLE;
              end
            end
          endcase
        end
        S_RDWAIT: begin
          res.done     <= 1'b1;
          res.cell_val <= ram_rdata;
          state        <= S_IDLE;
        end
        S_CLEAR: begin
          sc <= sc + 1'b1;
          if (sc == LAST_ADDR) begin
            res.done <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_SCROLL: begin
          if (sc != SCROLL_ADDR) begin
            rd_vld <= 1'b1;
            wr_q   <= sc;
            sc     <= sc + 1'b1;
          end else begin
            rd_vld <= 1'b0;
            state  <= S_BLANK;
          end
        end
        S_BLANK: begin
          sc <= sc + 1'b1;
          if (sc == LAST_ADDR) begin
            res.done     <= 1'b1;
            res.scrolled <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/text_console_writer_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console: cell store with cursor, put/read/clear commands.
//
// A command is transferred on the rising edge where start is high and busy
// is low; func, char_code and cell_index are sampled then. Commands are
// classified and placed in a two-entry queue, so up to two may wait while
// the engine works. Each command yields one result: done is high for one
// cycle with cursor_col, cursor_row, cursor_position, cell_value and
// scrolled valid in that cycle. The receiver cannot stall; results are
// never held back. A put, newline, backspace or unused code goes through
// the engine's fetch and execute steps; a read adds a step that waits for
// the registered RAM data. A clear blanks one cell per cycle through the
// single RAM write port, and a put or newline that scrolls moves one cell
// per cycle up a row and then blanks the last row. After reset, busy stays
// high while every cell is written blank.
// cfg_we/cfg_wdata load the attribute byte used by later puts.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        done,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_value,
  output logic        scrolled
);
  import tcw_pkg::*;

  q_stat_t    q_stat;
  back_stat_t back_stat;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  res_t       res;

  tcw_front u_front (
    .start      (start),
    .func       (func),
    .char_code  (char_code),
    .cell_index (cell_index),
    .q_stat     (q_stat),
    .back_stat  (back_stat),
    .busy       (busy),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (back_stat.pop),
    .head     (head),
    .stat     (q_stat)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .head      (head),
    .stat      (back_stat),
    .res       (res)
  );

  assign done            = res.done;
  assign cursor_col      = res.col;
  assign cursor_row      = res.row;
  assign cursor_position = res.pos;
  assign cell_value      = res.cell_val;
  assign scrolled        = res.scrolled;

endmodule

@@ tb/text_console_writer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking bench for the text console: a directed table covers reset
// contents, out-of-range reads, backspace at column zero, the unused function
// code and clear; random runs of text, newlines, backspaces, reads and clears
// then drive wrap and scroll under several attribute settings. Every result
// is compared field by field with a table entry or a shadow cell/cursor model.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int N_ITEMS    = 550;
  localparam int QUIET_FROM = 480;
  localparam int CFG_STRIDE = 110;
  localparam int LIMIT      = 5_000_000;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] pos;
    logic [15:0] cell_val;
    logic        scr;
  } cursor_rpt_t;

  typedef struct packed {
    logic [1:0]  fn;
    logic [7:0]  ch;
    logic [10:0] idx;
    logic        fixed;
    cursor_rpt_t rpt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  func = FUNC_PUT;
  logic [7:0]  char_code = 8'h00;
  logic [10:0] cell_index = 11'd0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        busy;
  logic        done;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_position;
  logic [15:0] cell_value;
  logic        scrolled;

  logic [15:0] shadow_cells [CELLS];
  int unsigned shadow_col;
  int unsigned shadow_row;
  logic [7:0]  shadow_attr;

  cursor_rpt_t pending_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  bit          gaps_on = 1'b0;

  dir_row_t dir_tab [0:18] = '{
    '{FUNC_READ,   8'h00,        11'd0,    1'b1, '{7'd0, 5'd0, 11'd0,  BLANK_CELL, 1'b0}},
    '{FUNC_READ,   8'hFF,        11'd1999, 1'b1, '{7'd0, 5'd0, 11'd0,  BLANK_CELL, 1'b0}},
    '{FUNC_READ,   8'h00,        11'd2047, 1'b1, '{7'd0, 5'd0, 11'd0,  16'h0000,   1'b0}},
    '{FUNC_READ,   8'h00,        11'd2000, 1'b1, '{7'd0, 5'd0, 11'd0,  16'h0000,   1'b0}},
    '{FUNC_PUT,    CH_BACKSPACE, 11'd0,    1'b1, '{7'd0, 5'd0, 11'd0,  16'h0000,   1'b0}},
    '{FUNC_UNUSED, 8'hFF,        11'd2047, 1'b1, '{7'd0, 5'd0, 11'd0,  16'h0000,   1'b0}},
    '{FUNC_PUT,    8'h41,        11'd0,    1'b1, '{7'd1, 5'd0, 11'd1,  16'h0000,   1'b0}},
    '{FUNC_PUT,    8'h00,        11'd2047, 1'b0, '0},
    '{FUNC_PUT,    8'hFF,        11'd0,    1'b0, '0},
    '{FUNC_READ,   8'h00,        11'd0,    1'b1, '{7'd3, 5'd0, 11'd3,  16'h0F41,   1'b0}},
    '{FUNC_READ,   8'h00,        11'd2,    1'b0, '0},
    '{FUNC_PUT,    CH_BACKSPACE, 11'd0,    1'b0, '0},
    '{FUNC_READ,   8'h00,        11'd2,    1'b0, '0},
    '{FUNC_PUT,    CH_NEWLINE,   11'd0,    1'b1, '{7'd0, 5'd1, 11'd80, 16'h0000,   1'b0}},
    '{FUNC_PUT,    8'h7F,        11'd0,    1'b0, '0},
    '{FUNC_UNUSED, 8'h00,        11'd0,    1'b0, '0},
    '{FUNC_CLEAR,  8'hFF,        11'd2047, 1'b1, '{7'd0, 5'd0, 11'd0,  16'h0000,   1'b0}},
    '{FUNC_READ,   8'h00,        11'd80,   1'b1, '{7'd0, 5'd0, 11'd0,  BLANK_CELL, 1'b0}},
    '{FUNC_CLEAR,  8'h00,        11'd0,    1'b1, '{7'd0, 5'd0, 11'd0,  16'h0000,   1'b0}}
  };

  text_console_writer_unit dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .done            (done),
    .cursor_col      (cursor_col),
    .cursor_row      (cursor_row),
    .cursor_position (cursor_position),
    .cell_value      (cell_value),
    .scrolled        (scrolled)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic cursor_rpt_t console_step(input logic [1:0] fn, input logic [7:0] ch,
                                               input logic [10:0] idx);
    cursor_rpt_t r;
    int i;
    r = '0;
    case (fn)
      FUNC_PUT: begin
        if (ch == CH_NEWLINE) begin
          shadow_col = 0;
          shadow_row++;
        end else if (ch == CH_BACKSPACE) begin
          if (shadow_col > 0) begin
            shadow_col--;
            shadow_cells[shadow_row * COLUMNS + shadow_col] = BLANK_CELL;
          end
        end else begin
          shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
          shadow_col++;
          if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        if (shadow_row >= ROWS) begin
          shadow_row = ROWS - 1;
          for (i = 0; i < SCROLL_END; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (i = SCROLL_END; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
          r.scr = 1'b1;
        end
      end
      FUNC_READ: begin
        if (idx < CELLS) r.cell_val = shadow_cells[idx];
      end
      FUNC_CLEAR: begin
        for (i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
        shadow_col = 0;
        shadow_row = 0;
      end
      default: ;
    endcase
    r.col = 7'(shadow_col);
    r.row = 5'(shadow_row);
    r.pos = 11'(shadow_row * COLUMNS + shadow_col);
    return r;
  endfunction

  task automatic issue(input logic [1:0] fn, input logic [7:0] ch, input logic [10:0] idx,
                       input bit fixed, input cursor_rpt_t typed);
    cursor_rpt_t p;
    start      <= 1'b1;
    func       <= fn;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (busy);
    p = console_step(fn, ch, idx);
    pending_q.push_back(fixed ? typed : p);
    n_sent++;
    if (gaps_on && n_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic set_attr(input logic [7:0] v);
    if (start) start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_attr = v;
  endtask

  always @(posedge clk) begin
    cursor_rpt_t got;
    cursor_rpt_t want;
    if (!rst && done) begin
      got = '{cursor_col, cursor_row, cursor_position, cell_value, scrolled};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: col %0d row %0d pos %0d cell %h scrolled %0d",
                   got.col, got.row, got.pos, got.cell_val, got.scr);
      end else begin
        want = pending_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp col %0d row %0d pos %0d cell %h scrolled %0d",
                      " / got col %0d row %0d pos %0d cell %h scrolled %0d"},
                     want.col, want.row, want.pos, want.cell_val, want.scr,
                     got.col, got.row, got.pos, got.cell_val, got.scr);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("text_console_writer_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    int k;
    int len;
    int kind;
    int phase;
    int next_cfg;
    logic [7:0]  ch;
    logic [10:0] idx;
    for (k = 0; k < CELLS; k++) shadow_cells[k] = BLANK_CELL;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = BLANK_ATTR;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    gaps_on = 1'b1;
    foreach (dir_tab[k])
      issue(dir_tab[k].fn, dir_tab[k].ch, dir_tab[k].idx, dir_tab[k].fixed, dir_tab[k].rpt);

    phase    = 0;
    next_cfg = 50;
    while (n_sent < N_ITEMS) begin
      if (n_sent >= next_cfg) begin
        case (phase % 5)
          0: set_attr(8'hFF);
          1: set_attr(8'h00);
          3: set_attr(8'h80);
          default: set_attr(8'($urandom_range(0, 255)));
        endcase
        phase++;
        next_cfg += CFG_STRIDE;
      end
      gaps_on = ($urandom_range(0, 1) == 0);
      kind    = $urandom_range(0, 19);
      if (kind < 9) begin
        len = $urandom_range(1, 90);
        repeat (len) begin
          ch = ($urandom_range(0, 19) == 0) ? CH_BACKSPACE : 8'($urandom_range(0, 255));
          issue(FUNC_PUT, ch, 11'($urandom_range(0, 2047)), 1'b0, '0);
        end
      end else if (kind < 13) begin
        len = $urandom_range(1, 30);
        repeat (len) issue(FUNC_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)), 1'b0, '0);
      end else if (kind < 17) begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0:       idx = 11'($urandom_range(CELLS, 2047));
            1, 2, 3: idx = 11'($urandom_range(0, CELLS - 1));
            default: idx = 11'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
          endcase
          issue(FUNC_READ, 8'($urandom_range(0, 255)), idx, 1'b0, '0);
        end
      end else if (kind < 18) begin
        issue(FUNC_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)), 1'b0, '0);
      end else if (kind < 19) begin
        issue(FUNC_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
              1'b0, '0);
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) issue(FUNC_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)), 1'b0, '0);
      end
    end

    if (start) start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("text_console_writer_unit_tb: clean");
    else
      $display("text_console_writer_unit_tb: errors");
    $finish;
  end

endmodule
